// ===== src/lbsg_pkg.sv =====
// ----------------------------------------------------------------------------
// lbsg_pkg - beacon settings guard shared definitions
// Target and status codes, payload structs, default settings and the
// default URI table used by the settings guard.
// ----------------------------------------------------------------------------
package lbsg_pkg;

   // Default sizes of the key and the URI store
   localparam int KEY_BYTES_DEF = 16;
   localparam int URI_BYTES_DEF = 18;

   // Data bytes carried by one request
   localparam int DATA_BYTES = 18;
   localparam int URI_LEN_W  = 5;

   // Default settings
   localparam int             DEF_URI_LEN    = 11;
   localparam logic [7:0]     PWR_DEFAULT_0  = 8'(256 - 38);
   localparam logic [7:0]     PWR_DEFAULT_1  = 8'(256 - 28);
   localparam logic [7:0]     PWR_DEFAULT_2  = 8'(256 - 22);
   localparam logic [7:0]     PWR_DEFAULT_3  = 8'(256 - 19);
   localparam logic [1:0]     DEF_POWER_MODE = 2'd2;
   localparam logic [15:0]    DEF_PERIOD     = 16'd1000;
   localparam logic [7:0]     MAX_POWER_MODE = 8'h03;

   // Required request lengths per target
   localparam logic [7:0] LEN_FLAGS   = 8'd1;
   localparam logic [7:0] LEN_LEVELS  = 8'd4;
   localparam logic [7:0] LEN_MODE    = 8'd1;
   localparam logic [7:0] LEN_PERIOD  = 8'd2;
   localparam logic [7:0] LEN_RESET   = 8'd1;

   typedef enum logic [2:0] {
      CMD_UNLOCK = 3'd0,
      CMD_LOCK   = 3'd1,
      CMD_URI    = 3'd2,
      CMD_FLAGS  = 3'd3,
      CMD_LEVELS = 3'd4,
      CMD_MODE   = 3'd5,
      CMD_PERIOD = 3'd6,
      CMD_RESET  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_NOT_PERMITTED = 2'd1,
      ST_NO_AUTH       = 2'd2,
      ST_BAD_LEN       = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  write_len;
      logic [63:0] data_lo;
      logic [63:0] data_mid;
      logic [15:0] data_hi;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 commit;
      logic                 locked_now;
      logic [7:0]           flags_now;
      logic [1:0]           power_mode_now;
      logic [15:0]          period_now;
      logic [31:0]          power_levels_now;
      logic [URI_LEN_W-1:0] uri_len_now;
      logic [63:0]          uri_lo_now;
      logic [63:0]          uri_mid_now;
      logic [15:0]          uri_hi_now;
   } rsp_payload_type;

   // Default URI bytes; positions past the default length are zero
   function automatic logic [7:0] default_uri_byte(input int idx);
      logic [7:0] b;
      case (idx)
         0:       b = 8'h00;
         1:       b = 8'h75;
         2:       b = 8'h63;
         3:       b = 8'h78;
         4:       b = 8'h70;
         5:       b = 8'h72;
         6:       b = 8'h65;
         7:       b = 8'h73;
         8:       b = 8'h73;
         9:       b = 8'h6F;
         10:      b = 8'h03;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== src/lbsg_req_if.sv =====
// ----------------------------------------------------------------------------
// lbsg_req_if - write request channel
// Valid/ready channel carrying one settings write request.
// ----------------------------------------------------------------------------
interface lbsg_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [7:0]  write_len;
   logic [63:0] data_lo;
   logic [63:0] data_mid;
   logic [15:0] data_hi;

   modport source (output valid, output cmd, output write_len, output data_lo,
                   output data_mid, output data_hi, input ready);
   modport sink   (input valid, input cmd, input write_len, input data_lo,
                   input data_mid, input data_hi, output ready);
endinterface

// ===== src/lbsg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lbsg_rsp_if - write response channel
// Valid/ready channel carrying the status and a settings snapshot.
// ----------------------------------------------------------------------------
interface lbsg_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        commit;
   logic        locked_now;
   logic [7:0]  flags_now;
   logic [1:0]  power_mode_now;
   logic [15:0] period_now;
   logic [31:0] power_levels_now;
   logic [4:0]  uri_len_now;
   logic [63:0] uri_lo_now;
   logic [63:0] uri_mid_now;
   logic [15:0] uri_hi_now;

   modport source (output valid, output status, output commit, output locked_now,
                   output flags_now, output power_mode_now, output period_now,
                   output power_levels_now, output uri_len_now, output uri_lo_now,
                   output uri_mid_now, output uri_hi_now, input ready);
   modport sink   (input valid, input status, input commit, input locked_now,
                   input flags_now, input power_mode_now, input period_now,
                   input power_levels_now, input uri_len_now, input uri_lo_now,
                   input uri_mid_now, input uri_hi_now, output ready);
endinterface

// ===== src/lockable_beacon_settings_guard.sv =====
// ----------------------------------------------------------------------------
// lockable_beacon_settings_guard - key-locked beacon settings store
// Takes settings write requests, checks lock and length, applies them and
// answers each with a status and a snapshot of the settings.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one write request: target, length and 18 data bytes.
//   rsp_chan returns exactly one response per request: status, commit flag
//   and the lock flag and settings as they stand after that request.
//   A request is registered on acceptance and decoded once the response
//   register is free; there the settings update and the response register
//   load together, and rsp_chan.valid is driven from the response register.
//   Throughput is one request per cycle while the receiver does not stall;
//   the settings registers written by one request are read by the next one.
//   When the receiver stalls, the response register holds and the request
//   register still takes one more request; after that req_chan.ready drops
//   until the response is taken.
//   Synchronous reset empties both registers and loads the default
//   settings: unlocked, zero key, default URI, flags zero, default power
//   levels, power mode 2 and a period of 1000 ms.
// ----------------------------------------------------------------------------
module lockable_beacon_settings_guard #(
   parameter int KEY_BYTES = lbsg_pkg::KEY_BYTES_DEF,
   parameter int URI_BYTES = lbsg_pkg::URI_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lbsg_req_if.sink   req_chan,
   lbsg_rsp_if.source rsp_chan
);

   logic                      req_valid_ff, req_valid_in;
   lbsg_pkg::req_payload_type req_data_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   lbsg_pkg::rsp_payload_type rsp_data_ff;
   lbsg_pkg::rsp_payload_type rsp_next;
   logic                      advance;
   logic                      req_take;

   // Move the held request on when the response register is free
   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
      rsp_valid_in = advance ? 1'b1 :
                     ((rsp_valid_ff && rsp_chan.ready) ? 1'b0 : rsp_valid_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff.cmd       <= req_chan.cmd;
         req_data_ff.write_len <= req_chan.write_len;
         req_data_ff.data_lo   <= req_chan.data_lo;
         req_data_ff.data_mid  <= req_chan.data_mid;
         req_data_ff.data_hi   <= req_chan.data_hi;
      end
   end

   lbsg_core #(
      .KEY_BYTES (KEY_BYTES),
      .URI_BYTES (URI_BYTES)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (req_data_ff),
      .rsp   (rsp_next)
   );

   // Capture the response snapshot
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // Drive the response channel
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_data_ff.status;
   assign rsp_chan.commit           = rsp_data_ff.commit;
   assign rsp_chan.locked_now       = rsp_data_ff.locked_now;
   assign rsp_chan.flags_now        = rsp_data_ff.flags_now;
   assign rsp_chan.power_mode_now   = rsp_data_ff.power_mode_now;
   assign rsp_chan.period_now       = rsp_data_ff.period_now;
   assign rsp_chan.power_levels_now = rsp_data_ff.power_levels_now;
   assign rsp_chan.uri_len_now      = rsp_data_ff.uri_len_now;
   assign rsp_chan.uri_lo_now       = rsp_data_ff.uri_lo_now;
   assign rsp_chan.uri_mid_now      = rsp_data_ff.uri_mid_now;
   assign rsp_chan.uri_hi_now       = rsp_data_ff.uri_hi_now;

endmodule

// ===== src/lbsg_core.sv =====
// ----------------------------------------------------------------------------
// lbsg_core - settings store and write decoder
// Holds the lock, key and beacon settings, applies one request when fire
// is high and presents the status with the post-request settings.
// ----------------------------------------------------------------------------
module lbsg_core #(
   parameter int KEY_BYTES = lbsg_pkg::KEY_BYTES_DEF,
   parameter int URI_BYTES = lbsg_pkg::URI_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  lbsg_pkg::req_payload_type req,
   output lbsg_pkg::rsp_payload_type rsp
);

   localparam int DEF_LEN = (URI_BYTES < lbsg_pkg::DEF_URI_LEN) ?
                            URI_BYTES : lbsg_pkg::DEF_URI_LEN;
   localparam int DATA_BYTES = lbsg_pkg::DATA_BYTES;

   logic                          lock_ff, lock_in;
   logic [7:0]                    key_ff [KEY_BYTES];
   logic [7:0]                    key_in [KEY_BYTES];
   logic [7:0]                    uri_ff [URI_BYTES];
   logic [7:0]                    uri_in [URI_BYTES];
   logic [lbsg_pkg::URI_LEN_W-1:0] uri_len_ff, uri_len_in;
   logic [7:0]                    flags_ff, flags_in;
   logic [7:0]                    pwr_ff [4];
   logic [7:0]                    pwr_in [4];
   logic [1:0]                    mode_ff, mode_in;
   logic [15:0]                   period_ff, period_in;

   logic [8*DATA_BYTES-1:0]       data_vec;
   logic [7:0]                    rb [DATA_BYTES];
   logic                          key_match;
   lbsg_pkg::status_type          status;
   logic                          commit;
   logic [8*DATA_BYTES-1:0]       uri_vec;

   // Split the request data into bytes
   assign data_vec = {req.data_hi, req.data_mid, req.data_lo};
   always_comb begin
      for (int i = 0; i < DATA_BYTES; i++) begin
         rb[i] = data_vec[8*i +: 8];
      end
   end

   // Compare the stored key with the request bytes
   always_comb begin
      key_match = 1'b1;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (key_ff[i] != rb[i]) key_match = 1'b0;
      end
   end

   // Decode the request and form the next settings
   always_comb begin
      lock_in    = lock_ff;
      key_in     = key_ff;
      uri_in     = uri_ff;
      uri_len_in = uri_len_ff;
      flags_in   = flags_ff;
      pwr_in     = pwr_ff;
      mode_in    = mode_ff;
      period_in  = period_ff;
      status     = lbsg_pkg::ST_OK;
      commit     = 1'b0;
      if (fire) begin
         // unlock check comes first and may clear the lock
         if (req.cmd == lbsg_pkg::CMD_UNLOCK) begin
            if (req.write_len == 8'(KEY_BYTES)) begin
               if (key_match) begin
                  lock_in = 1'b0;
                  commit  = 1'b1;
               end else begin
                  status = lbsg_pkg::ST_NO_AUTH;
               end
            end else begin
               status = lbsg_pkg::ST_BAD_LEN;
            end
         end
         if (!lock_in) begin
            case (req.cmd)
               lbsg_pkg::CMD_UNLOCK: begin
               end
               lbsg_pkg::CMD_LOCK: begin
                  if (req.write_len == 8'(KEY_BYTES)) begin
                     lock_in = 1'b1;
                     for (int i = 0; i < KEY_BYTES; i++) key_in[i] = rb[i];
                     commit = 1'b1;
                  end else begin
                     status = lbsg_pkg::ST_BAD_LEN;
                  end
               end
               lbsg_pkg::CMD_URI: begin
                  if (req.write_len <= 8'(URI_BYTES)) begin
                     for (int i = 0; i < URI_BYTES; i++) begin
                        if (req.write_len > 8'(i)) uri_in[i] = rb[i];
                     end
                     uri_len_in = lbsg_pkg::URI_LEN_W'(req.write_len);
                     commit     = 1'b1;
                  end else begin
                     status = lbsg_pkg::ST_BAD_LEN;
                  end
               end
               lbsg_pkg::CMD_FLAGS: begin
                  if (req.write_len == lbsg_pkg::LEN_FLAGS) begin
                     flags_in = rb[0];
                     commit   = 1'b1;
                  end else begin
                     status = lbsg_pkg::ST_BAD_LEN;
                  end
               end
               lbsg_pkg::CMD_LEVELS: begin
                  if (req.write_len == lbsg_pkg::LEN_LEVELS) begin
                     for (int i = 0; i < 4; i++) pwr_in[i] = rb[i];
                     commit = 1'b1;
                  end else begin
                     status = lbsg_pkg::ST_BAD_LEN;
                  end
               end
               lbsg_pkg::CMD_MODE: begin
                  if (req.write_len == lbsg_pkg::LEN_MODE) begin
                     if (rb[0] <= lbsg_pkg::MAX_POWER_MODE) begin
                        mode_in = rb[0][1:0];
                        commit  = 1'b1;
                     end else begin
                        status = lbsg_pkg::ST_NOT_PERMITTED;
                     end
                  end else begin
                     status = lbsg_pkg::ST_BAD_LEN;
                  end
               end
               lbsg_pkg::CMD_PERIOD: begin
                  if (req.write_len == lbsg_pkg::LEN_PERIOD) begin
                     period_in = {rb[1], rb[0]};
                     commit    = 1'b1;
                  end else begin
                     status = lbsg_pkg::ST_BAD_LEN;
                  end
               end
               lbsg_pkg::CMD_RESET: begin
                  if (req.write_len == lbsg_pkg::LEN_RESET) begin
                     lock_in = 1'b0;
                     for (int i = 0; i < KEY_BYTES; i++) key_in[i] = 8'h00;
                     for (int i = 0; i < URI_BYTES; i++) begin
                        uri_in[i] = lbsg_pkg::default_uri_byte(i);
                     end
                     uri_len_in = lbsg_pkg::URI_LEN_W'(DEF_LEN);
                     flags_in   = 8'h00;
                     pwr_in[0]  = lbsg_pkg::PWR_DEFAULT_0;
                     pwr_in[1]  = lbsg_pkg::PWR_DEFAULT_1;
                     pwr_in[2]  = lbsg_pkg::PWR_DEFAULT_2;
                     pwr_in[3]  = lbsg_pkg::PWR_DEFAULT_3;
                     mode_in    = lbsg_pkg::DEF_POWER_MODE;
                     period_in  = lbsg_pkg::DEF_PERIOD;
                     commit     = 1'b1;
                  end else begin
                     status = lbsg_pkg::ST_BAD_LEN;
                  end
               end
               default: begin
               end
            endcase
         end else begin
            // locked: refuse, overriding any unlock length error
            status = lbsg_pkg::ST_NO_AUTH;
         end
      end
   end

   // Hold the settings; reset loads the defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff <= 1'b0;
         for (int i = 0; i < KEY_BYTES; i++) key_ff[i] <= 8'h00;
         for (int i = 0; i < URI_BYTES; i++) begin
            uri_ff[i] <= lbsg_pkg::default_uri_byte(i);
         end
         uri_len_ff <= lbsg_pkg::URI_LEN_W'(DEF_LEN);
         flags_ff   <= 8'h00;
         pwr_ff[0]  <= lbsg_pkg::PWR_DEFAULT_0;
         pwr_ff[1]  <= lbsg_pkg::PWR_DEFAULT_1;
         pwr_ff[2]  <= lbsg_pkg::PWR_DEFAULT_2;
         pwr_ff[3]  <= lbsg_pkg::PWR_DEFAULT_3;
         mode_ff    <= lbsg_pkg::DEF_POWER_MODE;
         period_ff  <= lbsg_pkg::DEF_PERIOD;
      end else begin
         lock_ff    <= lock_in;
         key_ff     <= key_in;
         uri_ff     <= uri_in;
         uri_len_ff <= uri_len_in;
         flags_ff   <= flags_in;
         pwr_ff     <= pwr_in;
         mode_ff    <= mode_in;
         period_ff  <= period_in;
      end
   end

   // Pack the URI snapshot; positions past the store read as zero
   for (genvar p = 0; p < DATA_BYTES; p++) begin : g_uri_pack
      if (p < URI_BYTES) begin : g_used
         assign uri_vec[8*p +: 8] = uri_in[p];
      end else begin : g_zero
         assign uri_vec[8*p +: 8] = 8'h00;
      end
   end

   // Present the status with the post-request settings
   always_comb begin
      rsp.status           = status;
      rsp.commit           = commit;
      rsp.locked_now       = lock_in;
      rsp.flags_now        = flags_in;
      rsp.power_mode_now   = mode_in;
      rsp.period_now       = period_in;
      rsp.power_levels_now = {pwr_in[3], pwr_in[2], pwr_in[1], pwr_in[0]};
      rsp.uri_len_now      = uri_len_in;
      rsp.uri_lo_now       = uri_vec[63:0];
      rsp.uri_mid_now      = uri_vec[127:64];
      rsp.uri_hi_now       = uri_vec[143:128];
   end

endmodule

// ===== verif/tb_lockable_beacon_settings_guard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lockable_beacon_settings_guard - settings guard regression
// Drives write requests through the lock, length and range checks: a table
// of hand-picked requests first, then random request streams under changing
// sender and receiver stalls. Every response is compared field by field with
// a behavioural model of the guard kept in this bench.
// ----------------------------------------------------------------------------
module tb_lockable_beacon_settings_guard;

   localparam int          CYCLE_LIMIT = 300000;
   localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] KEY_LO      = 64'hA5A5_A5A5_A5A5_A5A5;
   localparam logic [63:0] KEY_HI      = 64'h5A5A_5A5A_5A5A_5A5A;

   // One hand-picked request, with status, commit and lock typed in where known
   typedef struct packed {
      lbsg_pkg::req_payload_type req;
      bit                        typed;
      logic [1:0]                st;
      bit                        commit_want;
      bit                        locked_want;
   } plan_entry_type;

   logic clock = 1'b0;
   logic reset;

   lbsg_req_if req_bus ();
   lbsg_rsp_if rsp_bus ();

   lockable_beacon_settings_guard u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Settings as the guard should hold them
   bit           guard_locked;
   logic [127:0] guard_key;
   logic [143:0] guard_uri;
   logic [4:0]   guard_uri_len;
   logic [7:0]   guard_flags;
   logic [31:0]  guard_levels;
   logic [1:0]   guard_mode;
   logic [15:0]  guard_period;

   lbsg_pkg::rsp_payload_type snapshot_q[$];
   int                        mismatch_count = 0;
   int                        cycle_count    = 0;
   int                        send_idle_pct  = 0;
   int                        recv_stall_pct = 0;

   // Toggle the clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Load the factory settings
   function automatic void restore_defaults();
      guard_locked  = 1'b0;
      guard_key     = '0;
      guard_uri     = '0;
      guard_uri[87:0] = {8'h03, 8'h6F, 8'h73, 8'h73, 8'h65, 8'h72, 8'h70, 8'h78,
                         8'h63, 8'h75, 8'h00};
      guard_uri_len = 5'd11;
      guard_flags   = 8'h00;
      guard_levels  = {8'hED, 8'hEA, 8'hE4, 8'hDA};
      guard_mode    = 2'd2;
      guard_period  = 16'd1000;
   endfunction

   // Apply one write to the settings and return the response it should get
   function automatic lbsg_pkg::rsp_payload_type apply_write(
         input lbsg_pkg::req_payload_type r);
      lbsg_pkg::rsp_payload_type s;
      logic [143:0]              bytes;
      logic [1:0]                st;
      bit                        changed;
      int                        i;
      bytes   = {r.data_hi, r.data_mid, r.data_lo};
      st      = lbsg_pkg::ST_OK;
      changed = 1'b0;
      // the key check runs whether or not the guard is locked
      if (r.cmd == lbsg_pkg::CMD_UNLOCK) begin
         if (r.write_len != 8'(lbsg_pkg::KEY_BYTES_DEF))
            st = lbsg_pkg::ST_BAD_LEN;
         else if (bytes[127:0] != guard_key)
            st = lbsg_pkg::ST_NO_AUTH;
         else begin
            guard_locked = 1'b0;
            changed      = 1'b1;
         end
      end
      if (guard_locked) begin
         st = lbsg_pkg::ST_NO_AUTH;
      end else begin
         case (r.cmd)
            lbsg_pkg::CMD_LOCK: begin
               if (r.write_len == 8'(lbsg_pkg::KEY_BYTES_DEF)) begin
                  guard_key    = bytes[127:0];
                  guard_locked = 1'b1;
                  changed      = 1'b1;
               end else st = lbsg_pkg::ST_BAD_LEN;
            end
            lbsg_pkg::CMD_URI: begin
               // replace only the bytes written, keep the tail
               if (r.write_len <= 8'(lbsg_pkg::URI_BYTES_DEF)) begin
                  for (i = 0; i < lbsg_pkg::URI_BYTES_DEF; i++)
                     if (i < r.write_len) guard_uri[8*i +: 8] = bytes[8*i +: 8];
                  guard_uri_len = 5'(r.write_len);
                  changed       = 1'b1;
               end else st = lbsg_pkg::ST_BAD_LEN;
            end
            lbsg_pkg::CMD_FLAGS: begin
               if (r.write_len == lbsg_pkg::LEN_FLAGS) begin
                  guard_flags = bytes[7:0];
                  changed     = 1'b1;
               end else st = lbsg_pkg::ST_BAD_LEN;
            end
            lbsg_pkg::CMD_LEVELS: begin
               if (r.write_len == lbsg_pkg::LEN_LEVELS) begin
                  guard_levels = bytes[31:0];
                  changed      = 1'b1;
               end else st = lbsg_pkg::ST_BAD_LEN;
            end
            lbsg_pkg::CMD_MODE: begin
               if (r.write_len != lbsg_pkg::LEN_MODE)
                  st = lbsg_pkg::ST_BAD_LEN;
               else if (bytes[7:0] > lbsg_pkg::MAX_POWER_MODE)
                  st = lbsg_pkg::ST_NOT_PERMITTED;
               else begin
                  guard_mode = bytes[1:0];
                  changed    = 1'b1;
               end
            end
            lbsg_pkg::CMD_PERIOD: begin
               if (r.write_len == lbsg_pkg::LEN_PERIOD) begin
                  guard_period = bytes[15:0];
                  changed      = 1'b1;
               end else st = lbsg_pkg::ST_BAD_LEN;
            end
            lbsg_pkg::CMD_RESET: begin
               if (r.write_len == lbsg_pkg::LEN_RESET) begin
                  restore_defaults();
                  changed = 1'b1;
               end else st = lbsg_pkg::ST_BAD_LEN;
            end
            default: ;
         endcase
      end
      s.status           = st;
      s.commit           = changed;
      s.locked_now       = guard_locked;
      s.flags_now        = guard_flags;
      s.power_mode_now   = guard_mode;
      s.period_now       = guard_period;
      s.power_levels_now = guard_levels;
      s.uri_len_now      = guard_uri_len;
      s.uri_lo_now       = guard_uri[63:0];
      s.uri_mid_now      = guard_uri[127:64];
      s.uri_hi_now       = guard_uri[143:128];
      return s;
   endfunction

   function automatic plan_entry_type plan_row(input lbsg_pkg::cmd_type c,
                                               input logic [7:0] len,
                                               input logic [63:0] lo, input logic [63:0] mid,
                                               input logic [15:0] hi, input bit typed,
                                               input lbsg_pkg::status_type st, input bit cm,
                                               input bit lk);
      plan_entry_type e;
      e.req.cmd       = c;
      e.req.write_len = len;
      e.req.data_lo   = lo;
      e.req.data_mid  = mid;
      e.req.data_hi   = hi;
      e.typed         = typed;
      e.st            = st;
      e.commit_want   = cm;
      e.locked_want   = lk;
      return e;
   endfunction

   // Build a random write, mostly well formed so the lock gets opened again
   function automatic lbsg_pkg::req_payload_type random_write();
      lbsg_pkg::req_payload_type r;
      int unsigned               pick;
      int unsigned               good_len;
      r.data_lo  = {$urandom, $urandom};
      r.data_mid = {$urandom, $urandom};
      r.data_hi  = 16'($urandom);
      pick       = $urandom_range(99);
      if (guard_locked && pick < 45)
         r.cmd = lbsg_pkg::CMD_UNLOCK;
      else if (pick < 52)
         r.cmd = lbsg_pkg::CMD_LOCK;
      else if (pick < 56)
         r.cmd = lbsg_pkg::CMD_RESET;
      else if (pick < 64)
         r.cmd = lbsg_pkg::CMD_UNLOCK;
      else
         r.cmd = 3'($urandom_range(lbsg_pkg::CMD_URI, lbsg_pkg::CMD_PERIOD));
      case (r.cmd)
         lbsg_pkg::CMD_UNLOCK, lbsg_pkg::CMD_LOCK: good_len = lbsg_pkg::KEY_BYTES_DEF;
         lbsg_pkg::CMD_URI:    good_len = $urandom_range(lbsg_pkg::URI_BYTES_DEF);
         lbsg_pkg::CMD_FLAGS:  good_len = 32'(lbsg_pkg::LEN_FLAGS);
         lbsg_pkg::CMD_LEVELS: good_len = 32'(lbsg_pkg::LEN_LEVELS);
         lbsg_pkg::CMD_MODE:   good_len = 32'(lbsg_pkg::LEN_MODE);
         lbsg_pkg::CMD_PERIOD: good_len = 32'(lbsg_pkg::LEN_PERIOD);
         default:              good_len = 32'(lbsg_pkg::LEN_RESET);
      endcase
      r.write_len = 8'(good_len);
      // break the length now and then
      if ($urandom_range(99) < 10) r.write_len = 8'($urandom_range(255));
      // present the stored key on most unlocks, a near miss on some
      if (r.cmd == lbsg_pkg::CMD_UNLOCK) begin
         pick = $urandom_range(99);
         if (pick < 80)
            {r.data_mid, r.data_lo} = guard_key;
         else if (pick < 90)
            {r.data_mid, r.data_lo} = guard_key ^ (128'd1 << $urandom_range(127));
      end
      // keep most power mode writes in range
      if (r.cmd == lbsg_pkg::CMD_MODE && $urandom_range(99) < 75)
         r.data_lo[7:0] = 8'($urandom_range(lbsg_pkg::MAX_POWER_MODE));
      return r;
   endfunction

   // Offer one request, hold it until taken, then predict its response
   task automatic accept_request(input lbsg_pkg::req_payload_type r,
                                 output lbsg_pkg::rsp_payload_type snap);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= r.cmd;
      req_bus.write_len <= r.write_len;
      req_bus.data_lo   <= r.data_lo;
      req_bus.data_mid  <= r.data_mid;
      req_bus.data_hi   <= r.data_hi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      snap = apply_write(r);
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   // Stall the response channel at random
   always @(posedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

   // Compare each response with the oldest outstanding snapshot
   always @(posedge clock) begin : check_responses
      lbsg_pkg::rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (snapshot_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response with no request outstanding", $time);
         end else begin
            want = snapshot_q.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_bus.status));
            check_field("commit", 64'(want.commit), 64'(rsp_bus.commit));
            check_field("locked_now", 64'(want.locked_now), 64'(rsp_bus.locked_now));
            check_field("flags_now", 64'(want.flags_now), 64'(rsp_bus.flags_now));
            check_field("power_mode_now", 64'(want.power_mode_now),
                        64'(rsp_bus.power_mode_now));
            check_field("period_now", 64'(want.period_now), 64'(rsp_bus.period_now));
            check_field("power_levels_now", 64'(want.power_levels_now),
                        64'(rsp_bus.power_levels_now));
            check_field("uri_len_now", 64'(want.uri_len_now), 64'(rsp_bus.uri_len_now));
            check_field("uri_lo_now", want.uri_lo_now, rsp_bus.uri_lo_now);
            check_field("uri_mid_now", want.uri_mid_now, rsp_bus.uri_mid_now);
            check_field("uri_hi_now", 64'(want.uri_hi_now), 64'(rsp_bus.uri_hi_now));
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("lockable_beacon_settings_guard regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      plan_entry_type            plan[$];
      lbsg_pkg::rsp_payload_type snap;
      int                        phase;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = lbsg_pkg::CMD_UNLOCK;
      req_bus.write_len = 8'd0;
      req_bus.data_lo   = '0;
      req_bus.data_mid  = '0;
      req_bus.data_hi   = '0;
      rsp_bus.ready     = 1'b0;
      restore_defaults();

      // plain writes from the factory settings, with their extremes
      plan.push_back(plan_row(lbsg_pkg::CMD_FLAGS, 8'd1, 64'hFF, '0, '0, 1,
                              lbsg_pkg::ST_OK, 1, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_FLAGS, 8'd1, 64'h0, '0, '0, 1,
                              lbsg_pkg::ST_OK, 1, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_MODE, 8'd1, 64'h3, '0, '0, 1,
                              lbsg_pkg::ST_OK, 1, 0));
      // power mode out of range and a wrong length
      plan.push_back(plan_row(lbsg_pkg::CMD_MODE, 8'd1, 64'h4, '0, '0, 1,
                              lbsg_pkg::ST_NOT_PERMITTED, 0, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_MODE, 8'd1, ALL_ONES, '0, '0, 1,
                              lbsg_pkg::ST_NOT_PERMITTED, 0, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_MODE, 8'd0, 64'h1, '0, '0, 1,
                              lbsg_pkg::ST_BAD_LEN, 0, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_PERIOD, 8'd2, 64'hFFFF, '0, '0, 1,
                              lbsg_pkg::ST_OK, 1, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_PERIOD, 8'd2, 64'h0, '0, '0, 1,
                              lbsg_pkg::ST_OK, 1, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_PERIOD, 8'd255, ALL_ONES, '0, '0, 1,
                              lbsg_pkg::ST_BAD_LEN, 0, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_LEVELS, 8'd4, 64'h807F_00FF, '0, '0, 1,
                              lbsg_pkg::ST_OK, 1, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_LEVELS, 8'd3, ALL_ONES, '0, '0, 1,
                              lbsg_pkg::ST_BAD_LEN, 0, 0));
      // URI: full, partial over the old tail, empty, one too long
      plan.push_back(plan_row(lbsg_pkg::CMD_URI, 8'd18, ALL_ONES, ALL_ONES, 16'hFFFF, 1,
                              lbsg_pkg::ST_OK, 1, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_URI, 8'd3, 64'h0012_3456, '0, '0, 0,
                              lbsg_pkg::ST_OK, 0, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_URI, 8'd0, ALL_ONES, '0, '0, 1,
                              lbsg_pkg::ST_OK, 1, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_URI, 8'd19, '0, '0, '0, 1,
                              lbsg_pkg::ST_BAD_LEN, 0, 0));
      // unlock while already unlocked
      plan.push_back(plan_row(lbsg_pkg::CMD_UNLOCK, 8'd16, '0, '0, '0, 1,
                              lbsg_pkg::ST_OK, 1, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_UNLOCK, 8'd16, ALL_ONES, ALL_ONES, '0, 1,
                              lbsg_pkg::ST_NO_AUTH, 0, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_UNLOCK, 8'd15, '0, '0, '0, 1,
                              lbsg_pkg::ST_BAD_LEN, 0, 0));
      // lock, then refused writes, then the right key
      plan.push_back(plan_row(lbsg_pkg::CMD_LOCK, 8'd15, KEY_LO, KEY_HI, '0, 1,
                              lbsg_pkg::ST_BAD_LEN, 0, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_LOCK, 8'd16, KEY_LO, KEY_HI, '0, 1,
                              lbsg_pkg::ST_OK, 1, 1));
      plan.push_back(plan_row(lbsg_pkg::CMD_RESET, 8'd1, '0, '0, '0, 1,
                              lbsg_pkg::ST_NO_AUTH, 0, 1));
      plan.push_back(plan_row(lbsg_pkg::CMD_UNLOCK, 8'd0, KEY_LO, KEY_HI, '0, 1,
                              lbsg_pkg::ST_NO_AUTH, 0, 1));
      plan.push_back(plan_row(lbsg_pkg::CMD_UNLOCK, 8'd16, KEY_LO ^ 64'h1, KEY_HI, '0, 1,
                              lbsg_pkg::ST_NO_AUTH, 0, 1));
      plan.push_back(plan_row(lbsg_pkg::CMD_UNLOCK, 8'd16, KEY_LO, KEY_HI, '0, 1,
                              lbsg_pkg::ST_OK, 1, 0));
      // reset target: wrong length, then the defaults
      plan.push_back(plan_row(lbsg_pkg::CMD_RESET, 8'd0, '0, '0, '0, 1,
                              lbsg_pkg::ST_BAD_LEN, 0, 0));
      plan.push_back(plan_row(lbsg_pkg::CMD_RESET, 8'd1, '0, '0, '0, 1,
                              lbsg_pkg::ST_OK, 1, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 19;
      recv_stall_pct = 73;
      foreach (plan[i]) begin
         accept_request(plan[i].req, snap);
         if (plan[i].typed) begin
            snap.status     = plan[i].st;
            snap.commit     = plan[i].commit_want;
            snap.locked_now = plan[i].locked_want;
         end
         snapshot_q.push_back(snap);
      end

      for (phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct  = 73;
            recv_stall_pct = 19;
         end else if (phase == 2) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         repeat (phase == 2 ? 560 : 570) begin
            accept_request(random_write(), snap);
            snapshot_q.push_back(snap);
         end
         // hold requests back until every outstanding response is in
         req_bus.valid <= 1'b0;
         do @(posedge clock); while (snapshot_q.size() != 0);
      end

      // let any late response show up
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && snapshot_q.size() == 0)
         $display("lockable_beacon_settings_guard regression: pass");
      else
         $display("lockable_beacon_settings_guard regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
src/lbsg_pkg.sv
src/lbsg_req_if.sv
src/lbsg_rsp_if.sv
src/lbsg_core.sv
src/lockable_beacon_settings_guard.sv
verif/tb_lockable_beacon_settings_guard.sv
